### rtl/bpk_pkg.sv
`timescale 1ns / 1ps
package bpk_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned PEND_BITS = 7;
  localparam int unsigned CODE_MAX  = 32;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] code;
    logic [5:0]  len;
  } q_item_t;

endpackage

### rtl/bpk_front.sv
`timescale 1ns / 1ps
module bpk_front #(
  parameter int CODE_W = 32,
  parameter int SYM_N  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpk_pkg::in_item_t in_item,
  output logic              q_push,
  output bpk_pkg::q_item_t  q_wdata,
  input  logic              q_full
);
  import bpk_pkg::*;

  localparam int IDX_W = (SYM_N > 1) ? $clog2(SYM_N) : 1;
  localparam int LEN_W = $clog2(CODE_W + 1);
  localparam int ENT_W = LEN_W + CODE_W;

  logic [ENT_W-1:0]  tbl_mem [SYM_N];
  logic [SYM_N-1:0]  tbl_vld_r;
  logic [SYM_N-1:0]  tbl_vld_nxt;
  logic [ENT_W-1:0]  rd_r;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic              s1_kind_r;
  logic              s1_hit_r;
  logic              acc;
  logic              in_table;
  logic              wr_en;
  logic              need;
  logic [IDX_W-1:0]  idx;
  logic [5:0]        len_c;
  logic [CODE_W-1:0] code_m;
  logic [LEN_W-1:0]  rd_len;
  logic [CODE_W-1:0] rd_code;

  assign idx      = in_item.symbol[IDX_W-1:0];
  assign in_table = ({1'b0, in_item.symbol} < 9'(SYM_N));
  assign acc      = in_valid && !in_stall;
  assign wr_en    = acc && (in_item.action == ACT_LOAD) && in_table;

  always_comb begin
    len_c = (in_item.code_length > 6'(CODE_W)) ? 6'(CODE_W) : in_item.code_length;
    for (int i = 0; i < CODE_W; i++) begin
      code_m[i] = in_item.code_bits[i] && (6'(i) < len_c);
    end
  end

  assign rd_len  = s1_hit_r ? rd_r[ENT_W-1 -: LEN_W] : '0;
  assign rd_code = rd_r[CODE_W-1:0];

  assign need     = s1_vld_r && ((s1_kind_r == KIND_FINISH) || (rd_len != '0));
  assign in_stall = need && q_full;
  assign q_push   = need && !q_full;

  always_comb begin
    q_wdata.kind = s1_kind_r;
    q_wdata.code = 32'(rd_code);
    q_wdata.len  = 6'(rd_len);
  end

  always_comb begin
    tbl_vld_nxt = tbl_vld_r;
    if (wr_en) begin
      tbl_vld_nxt[idx] = 1'b1;
    end
    if (acc) begin
      s1_vld_nxt = (in_item.action == ACT_ENCODE) || (in_item.action == ACT_FINISH);
    end else begin
      s1_vld_nxt = in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[idx] <= {LEN_W'(len_c), code_m};
    end
    if (acc) begin
      rd_r      <= tbl_mem[idx];
      s1_kind_r <= (in_item.action == ACT_FINISH) ? KIND_FINISH : KIND_ENCODE;
      s1_hit_r  <= in_table && tbl_vld_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      tbl_vld_r <= tbl_vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
    end
  end

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_vld_r)
    else $error("front stage lost an item while stalled");

endmodule

### rtl/bpk_fifo.sv
`timescale 1ns / 1ps
module bpk_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bpk_pkg::q_item_t wdata,
  output logic             full,
  input  logic             pop,
  output bpk_pkg::q_item_t rdata,
  output logic             not_empty
);
  import bpk_pkg::*;

  q_item_t           q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue underflow");

endmodule

### rtl/bpk_packer.sv
`timescale 1ns / 1ps
module bpk_packer #(
  parameter int CODE_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  bpk_pkg::q_item_t   q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bpk_pkg::out_item_t out_item
);
  import bpk_pkg::*;

  localparam int W     = PEND_BITS + CODE_W;
  localparam int REM_W = $clog2(W + 1);
  localparam logic [REM_W-1:0] BYTE_R = REM_W'(BYTE_BITS);
  localparam logic [REM_W-1:0] W_R    = REM_W'(W);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } st_t;

  st_t              st_r;
  st_t              st_nxt;
  logic [W-1:0]     w_r;
  logic [W-1:0]     w_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic             ov_r;
  logic             ov_nxt;
  out_item_t        out_r;
  out_item_t        out_nxt;
  logic             out_free;
  logic [W-1:0]     code_ext;
  logic [REM_W-1:0] len_ext;
  logic [REM_W-1:0] total;
  logic [REM_W-1:0] sh;
  logic [W-1:0]     merged;
  logic [REM_W-1:0] rem_dec;

  assign out_valid = ov_r;
  assign out_item  = out_r;
  assign out_free  = !ov_r || !out_stall;

  assign code_ext = {{PEND_BITS{1'b0}}, q_item.code[CODE_W-1:0]};
  assign len_ext  = REM_W'(q_item.len);
  assign total    = rem_r + len_ext;
  assign sh       = W_R - total;
  assign merged   = (code_ext << sh) | {w_r[W-1 -: PEND_BITS], {CODE_W{1'b0}}};
  assign rem_dec  = rem_r - BYTE_R;

  always_comb begin
    st_nxt  = st_r;
    w_nxt   = w_r;
    rem_nxt = rem_r;
    pop     = 1'b0;
    ov_nxt  = ov_r && out_stall;
    out_nxt = out_r;
    case (st_r)
      ST_IDLE: begin
        if (q_vld) begin
          if (q_item.kind == KIND_FINISH) begin
            if (out_free) begin
              pop     = 1'b1;
              w_nxt   = '0;
              rem_nxt = '0;
              if (rem_r != '0) begin
                ov_nxt              = 1'b1;
                out_nxt.packed_byte = {w_r[W-1 -: PEND_BITS], 1'b0};
                out_nxt.last_of_run = 1'b1;
              end
            end
          end else begin
            pop     = 1'b1;
            w_nxt   = merged;
            rem_nxt = total;
            if (total >= BYTE_R) begin
              st_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt              = 1'b1;
          out_nxt.packed_byte = w_r[W-1 -: BYTE_BITS];
          out_nxt.last_of_run = (rem_dec < BYTE_R);
          w_nxt               = w_r << BYTE_BITS;
          rem_nxt             = rem_dec;
          if (rem_dec < BYTE_R) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      w_r   <= '0;
      rem_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      w_r   <= w_nxt;
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (rem_r < BYTE_R))
    else $error("idle with a full byte pending");

  a_emit_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> (rem_r >= BYTE_R) && (rem_r <= W_R))
    else $error("emit without a full byte");

endmodule

### rtl/huffman_code_bit_packer_unit.sv
`timescale 1ns / 1ps
// Huffman code bit packer.
// Input channel (in_valid / in_stall / in_item): load items write a code
// and its length into the symbol table, encode items append the code of a
// symbol to the bit stream, finish items flush the last partial byte with
// zero padding. Load items and items that add no full byte give no output.
// Output channel (out_valid / out_stall / out_item): one packed byte per
// item, earliest code bit in the MSB; last_of_run marks the final byte
// caused by an input item.
// With an empty queue the first byte of an encode item passes through the
// table read register, the queue, the packer accumulator and the output
// register; the flushed byte of a finish item skips the accumulator.
// The front takes one item per cycle while its four-entry queue has room;
// the packer takes no new queued item until it has emitted every full byte
// of the item before, so an encode item that yields bytes holds the queue.
// Reset empties the table (every entry reads as no code), the queue and the
// bit accumulator. A stalled receiver holds the output byte; the packer then
// stops and the queue fills, after which in_stall rises.
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LENGTH = 32,
  parameter int SYMBOL_COUNT    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpk_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bpk_pkg::out_item_t out_item
);
  import bpk_pkg::*;

  localparam int CODE_W = (MAX_CODE_LENGTH < CODE_MAX) ? MAX_CODE_LENGTH : CODE_MAX;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_vld;
  q_item_t q_wdata;
  q_item_t q_rdata;

  bpk_front #(
    .CODE_W (CODE_W),
    .SYM_N  (SYMBOL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  bpk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_vld)
  );

  bpk_packer #(
    .CODE_W (CODE_W)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_item    (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
